// ----- hdl/ugli_pkg.sv -----
`default_nettype none
package ugli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PT_W        = 9;
    localparam int STEP_W      = 31;
    localparam int SPAN_W      = IDX_W + STEP_W;
    localparam int VAL_W       = 16;

    localparam int NORM_STEPS  = 5;
    localparam int FRAC_STEPS  = 16;
    localparam int DIV_BITS    = IDX_W + 16;

    localparam logic [31:0] LOG10_OF_2_Q32 = 32'd1292913986;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    localparam logic [1:0] CFG_LOG_MODE    = 2'd0;
    localparam logic [1:0] CFG_GRID_START  = 2'd1;
    localparam logic [1:0] CFG_GRID_STEP   = 2'd2;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_NORM,
        S_SQUARE,
        S_SCALE,
        S_ROUND,
        S_CHECK,
        S_DIV,
        S_LOAD_LO,
        S_LOAD_HI,
        S_MUL_HI,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_tbl_req;

endpackage
`default_nettype wire

// ----- hdl/ugli_in_if.sv -----
`default_nettype none
interface ugli_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
    logic [31:0] x_value;

    modport source (
        output valid, mode, entry_index, entry_value, x_value,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, entry_value, x_value,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/ugli_out_if.sv -----
`default_nettype none
interface ugli_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] interpolated;
    logic        out_of_range;

    modport source (
        output valid, interpolated, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, interpolated, out_of_range,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/ugli_table.sv -----
`default_nettype none
module ugli_table (
    input  wire logic                       i_clk,
    input  wire ugli_pkg::t_tbl_req         i_req,
    output logic [ugli_pkg::VAL_W-1:0]      o_rdata
);

    logic [ugli_pkg::VAL_W-1:0] r_mem [ugli_pkg::TABLE_DEPTH];
    logic [ugli_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/ugli_mult.sv -----
`default_nettype none
module ugli_mult (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    assign o_p = 64'(i_a) * 64'(i_b);

endmodule
`default_nettype wire

// ----- hdl/uniform_grid_linear_interpolator.sv -----
`default_nettype none
// An evaluation runs through the 24-step serial divider and, in log mode, 16 squaring passes
// on the shared 32x32 multiplier. A write beat goes to the table and leaves the sequencer idle.
// The input is not ready during an evaluation, so a new evaluate beat is taken only once the
// result has entered the output register, later if the previous result still waits there.
// Synchronous active-low reset idles the sequencer, empties the output register and
// loads the register defaults; the table is not cleared.
module uniform_grid_linear_interpolator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ugli_in_if.sink          i_in,
    ugli_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IW = ugli_pkg::IDX_W;
    localparam int SW = ugli_pkg::STEP_W;
    localparam int QW = ugli_pkg::DIV_BITS;
    localparam int VW = ugli_pkg::VAL_W;

    ugli_pkg::t_state r_state, n_state;

    logic                      r_log_mode, n_log_mode;
    logic signed [31:0]        r_grid_start, n_grid_start;
    logic [SW-1:0]             r_grid_step, n_grid_step;
    logic [ugli_pkg::PT_W-1:0] r_point_count, n_point_count;

    logic          r_out_valid, n_out_valid;
    logic [VW-1:0] r_out_val, n_out_val;
    logic          r_out_oor, n_out_oor;

    logic [31:0]              r_x, n_x;
    logic [SW-1:0]            r_step, n_step;
    logic [IW-1:0]            r_nm1, n_nm1;
    logic [ugli_pkg::SPAN_W-1:0] r_span, n_span;
    logic [31:0]              r_m, n_m;
    logic [4:0]               r_msb, n_msb;
    logic [15:0]              r_frac, n_frac;
    logic [51:0]              r_prod, n_prod;
    logic                     r_neg, n_neg;
    logic signed [33:0]       r_xq, n_xq;
    logic [31:0]              r_rem, n_rem;
    logic [7:0]               r_dsh, n_dsh;
    logic [QW-1:0]            r_q, n_q;
    logic [IW-1:0]            r_idx, n_idx;
    logic [16:0]              r_w, n_w;
    logic [32:0]              r_acc, n_acc;
    logic                     r_oor, n_oor;
    logic [4:0]               r_cnt, n_cnt;

    logic                 in_ready;
    logic                 out_free;
    logic [SW-1:0]        step_eff;
    logic [ugli_pkg::PT_W-1:0] n_eff;
    logic [IW-1:0]        nm1_eff;
    logic [4:0]           norm_sh;
    logic signed [20:0]   log2v;
    logic [20:0]          log2_mag;
    logic [51:0]          prod_rnd;
    logic [19:0]          log10_mag;
    logic signed [33:0]   diff;
    logic [31:0]          trial;
    logic [IW-1:0]        q_idx;
    logic [32:0]          acc_rnd;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    ugli_pkg::t_tbl_req   tbl_req;
    logic [VW-1:0]        tbl_rdata;

    ugli_mult u_mult (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    ugli_table u_table (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

    always_comb begin
        step_eff = (r_grid_step == '0) ? SW'(1) : r_grid_step;
        if (r_point_count < ugli_pkg::PT_W'(2)) begin
            n_eff = ugli_pkg::PT_W'(2);
        end else if (r_point_count > ugli_pkg::PT_W'(ugli_pkg::TABLE_DEPTH)) begin
            n_eff = ugli_pkg::PT_W'(ugli_pkg::TABLE_DEPTH);
        end else begin
            n_eff = r_point_count;
        end
        nm1_eff   = IW'(n_eff - ugli_pkg::PT_W'(1));
        norm_sh   = 5'd16 >> r_cnt;
        log2v     = {~r_msb[4], r_msb[3:0], r_frac};
        log2_mag  = log2v[20] ? 21'(-log2v) : 21'(log2v);
        prod_rnd  = r_prod + 52'h0_8000_0000;
        log10_mag = prod_rnd[51:32];
        diff      = r_xq - {{2{r_grid_start[31]}}, r_grid_start};
        trial     = {r_rem[30:0], r_dsh[7]};
        q_idx     = r_q[QW-1:16];
        acc_rnd   = r_acc + 33'h0_8000;
    end

    always_comb begin
        n_state       = r_state;
        n_log_mode    = r_log_mode;
        n_grid_start  = r_grid_start;
        n_grid_step   = r_grid_step;
        n_point_count = r_point_count;
        n_out_valid   = r_out_valid;
        n_out_val     = r_out_val;
        n_out_oor     = r_out_oor;
        n_x    = r_x;
        n_step = r_step;
        n_nm1  = r_nm1;
        n_span = r_span;
        n_m    = r_m;
        n_msb  = r_msb;
        n_frac = r_frac;
        n_prod = r_prod;
        n_neg  = r_neg;
        n_xq   = r_xq;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_idx  = r_idx;
        n_w    = r_w;
        n_acc  = r_acc;
        n_oor  = r_oor;
        n_cnt  = r_cnt;
        mul_a   = '0;
        mul_b   = '0;
        tbl_req = '0;

        in_ready = (r_state == ugli_pkg::S_IDLE);
        out_free = !r_out_valid || o_out.ready;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ugli_pkg::CFG_LOG_MODE:    n_log_mode    = i_cfg_data[0];
                ugli_pkg::CFG_GRID_START:  n_grid_start  = signed'(i_cfg_data);
                ugli_pkg::CFG_GRID_STEP:   n_grid_step   = i_cfg_data[SW-1:0];
                ugli_pkg::CFG_POINT_COUNT: n_point_count = i_cfg_data[ugli_pkg::PT_W-1:0];
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ugli_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.mode == ugli_pkg::MODE_WRITE) begin
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = i_in.entry_index;
                        tbl_req.wdata = i_in.entry_value;
                    end else begin
                        n_x     = i_in.x_value;
                        n_step  = step_eff;
                        n_nm1   = nm1_eff;
                        n_oor   = 1'b0;
                        n_state = ugli_pkg::S_SPAN;
                    end
                end
            end
            ugli_pkg::S_SPAN: begin
                mul_a  = 32'(r_nm1);
                mul_b  = 32'(r_step);
                n_span = mul_p[ugli_pkg::SPAN_W-1:0];
                if (r_log_mode) begin
                    if (r_x == '0) begin
                        n_oor         = 1'b1;
                        tbl_req.re    = 1'b1;
                        tbl_req.raddr = '0;
                        n_state       = ugli_pkg::S_FINISH;
                    end else begin
                        n_m     = r_x;
                        n_msb   = 5'd31;
                        n_cnt   = '0;
                        n_state = ugli_pkg::S_NORM;
                    end
                end else begin
                    n_xq    = signed'({2'b00, r_x});
                    n_state = ugli_pkg::S_CHECK;
                end
            end
            ugli_pkg::S_NORM: begin
                if ((r_m & ~(32'hFFFF_FFFF >> norm_sh)) == '0) begin
                    n_m   = r_m << norm_sh;
                    n_msb = r_msb - norm_sh;
                end
                if (r_cnt == 5'(ugli_pkg::NORM_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_frac  = '0;
                    n_state = ugli_pkg::S_SQUARE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ugli_pkg::S_SQUARE: begin
                mul_a = r_m;
                mul_b = r_m;
                if (mul_p[63]) begin
                    n_m    = mul_p[63:32];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_m    = mul_p[62:31];
                    n_frac = {r_frac[14:0], 1'b0};
                end
                if (r_cnt == 5'(ugli_pkg::FRAC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ugli_pkg::S_SCALE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ugli_pkg::S_SCALE: begin
                mul_a   = 32'(log2_mag);
                mul_b   = ugli_pkg::LOG10_OF_2_Q32;
                n_prod  = mul_p[51:0];
                n_neg   = log2v[20];
                n_state = ugli_pkg::S_ROUND;
            end
            ugli_pkg::S_ROUND: begin
                n_xq    = r_neg ? -signed'({14'b0, log10_mag}) : signed'({14'b0, log10_mag});
                n_state = ugli_pkg::S_CHECK;
            end
            ugli_pkg::S_CHECK: begin
                if (diff[33]) begin
                    n_oor         = 1'b1;
                    tbl_req.re    = 1'b1;
                    tbl_req.raddr = '0;
                    n_state       = ugli_pkg::S_FINISH;
                end else if ({6'b0, diff[32:0]} > r_span) begin
                    n_oor         = 1'b1;
                    tbl_req.re    = 1'b1;
                    tbl_req.raddr = r_nm1;
                    n_state       = ugli_pkg::S_FINISH;
                end else begin
                    n_rem   = {7'b0, diff[32:8]};
                    n_dsh   = diff[7:0];
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = ugli_pkg::S_DIV;
                end
            end
            ugli_pkg::S_DIV: begin
                if (trial >= {1'b0, r_step}) begin
                    n_rem = trial - {1'b0, r_step};
                    n_q   = {r_q[QW-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_q   = {r_q[QW-2:0], 1'b0};
                end
                n_dsh = {r_dsh[6:0], 1'b0};
                if (r_cnt == 5'(QW - 1)) begin
                    n_cnt   = '0;
                    n_state = ugli_pkg::S_LOAD_LO;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ugli_pkg::S_LOAD_LO: begin
                // A coordinate exactly on the last grid point lands in the last cell at full weight.
                if (q_idx >= r_nm1) begin
                    n_idx = r_nm1 - IW'(1);
                    n_w   = 17'h1_0000;
                end else begin
                    n_idx = q_idx;
                    n_w   = {1'b0, r_q[15:0]};
                end
                tbl_req.re    = 1'b1;
                tbl_req.raddr = n_idx;
                n_state       = ugli_pkg::S_LOAD_HI;
            end
            ugli_pkg::S_LOAD_HI: begin
                tbl_req.re    = 1'b1;
                tbl_req.raddr = r_idx + IW'(1);
                mul_a         = 32'(tbl_rdata);
                mul_b         = 32'(17'h1_0000 - r_w);
                n_acc         = {1'b0, mul_p[31:0]};
                n_state       = ugli_pkg::S_MUL_HI;
            end
            ugli_pkg::S_MUL_HI: begin
                mul_a   = 32'(tbl_rdata);
                mul_b   = 32'(r_w);
                n_acc   = r_acc + {1'b0, mul_p[31:0]};
                n_state = ugli_pkg::S_FINISH;
            end
            ugli_pkg::S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_oor ? tbl_rdata : acc_rnd[31:16];
                    n_out_oor   = r_oor;
                    n_state     = ugli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ugli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ugli_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_log_mode    <= 1'b0;
            r_grid_start  <= '0;
            r_grid_step   <= SW'(65536);
            r_point_count <= ugli_pkg::PT_W'(256);
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_log_mode    <= n_log_mode;
            r_grid_start  <= n_grid_start;
            r_grid_step   <= n_grid_step;
            r_point_count <= n_point_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= n_out_val;
        r_out_oor <= n_out_oor;
        r_x    <= n_x;
        r_step <= n_step;
        r_nm1  <= n_nm1;
        r_span <= n_span;
        r_m    <= n_m;
        r_msb  <= n_msb;
        r_frac <= n_frac;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_xq   <= n_xq;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_idx  <= n_idx;
        r_w    <= n_w;
        r_acc  <= n_acc;
        r_oor  <= n_oor;
        r_cnt  <= n_cnt;
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.interpolated = r_out_val;
    assign o_out.out_of_range = r_out_oor;

    a_busy_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == ugli_pkg::MODE_EVAL)
        |=> (r_state != ugli_pkg::S_IDLE))
        else $error("Sequencer stayed idle after an evaluate beat.");

    a_rem_below_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ugli_pkg::S_DIV) |-> (r_rem < {1'b0, r_step}))
        else $error("Divider remainder reached the grid step.");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ugli_pkg::S_SQUARE) |-> r_m[31])
        else $error("Log mantissa lost its leading one.");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ugli_pkg::S_FINISH))
        else $error("Result beat appeared outside the finish step.");

endmodule
`default_nettype wire
